@@ hw/rtl/udm_pkg.sv @@
`default_nettype none

package udm_pkg;

  // Default operand and result width.
  localparam int DATA_WIDTH_DEFAULT = 64;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Control handed from the sequencer to the cell row and output stage.
  typedef struct packed {
    logic load;    // capture a new request into the cells
    logic step;    // perform one shift-and-subtract step
    logic finish;  // move the finished result into the output register
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/udm_cell.sv @@
`default_nettype none

module udm_cell
  import udm_pkg::*;
(
  input  wire logic clk,
  input  wire ctl_t ctl,
  input  wire logic q_init,
  input  wire logic d_init,
  input  wire logic q_in,
  input  wire logic r_in,
  input  wire logic sel,
  input  wire logic borrow_in,
  output logic      q,
  output logic      r,
  output logic      borrow_out,
  output logic      d
);

  logic diff;

  // One bit of the trial subtraction of the divisor from the shifted remainder.
  assign diff       = r_in ^ d ^ borrow_in;
  assign borrow_out = (~r_in & (d | borrow_in)) | (d & borrow_in);

  // Remainder, quotient and divisor bits of this column.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= q_init;
      r <= 1'b0;
      d <= d_init;
    end else if (ctl.step) begin
      q <= q_in;
      r <= sel ? diff : r_in;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/udm_ctrl.sv @@
`default_nettype none

module udm_ctrl
  import udm_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_free,
  output logic      in_ready,
  output ctl_t      ctl
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RUN;
      ST_RUN:  if (count == LAST) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    ctl.load   = 1'b0;
    ctl.step   = 1'b0;
    ctl.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_RUN:  ctl.step = 1'b1;
      ST_HOLD: ctl.finish = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // State register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        count <= '0;
      end else if (ctl.step) begin
        count <= count + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_load_step_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.load && ctl.step)) else $error("load and step at once");
  a_load_then_run: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (ctl.step && count == '0)) else $error("run did not start");
  a_last_then_hold: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && count == LAST) |=> (state == ST_HOLD)) else $error("run overran");
  a_finish_then_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> in_ready) else $error("not idle after finish");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/unsigned_divmod_64.sv @@
// Unsigned integer divider: quotient and remainder of two DATA_WIDTH-bit operands.
//
// Requests arrive on in_valid/in_ready with dividend and divisor; results leave
// on out_valid/out_ready with quotient, remainder and divide_by_zero.
// A row of DATA_WIDTH bit cells performs restoring division, one quotient bit
// per cycle, the trial subtraction rippling its borrow along the row.
// The request is captured at the accepting edge, DATA_WIDTH shift-and-subtract
// steps follow, and then the result moves into the output register and out_valid
// rises. in_ready is high only while the cell row is empty, so a new request is
// taken only after the previous one has left the cell row, but also while the
// previous result still waits in the output register.
// A zero divisor gives quotient and remainder zero and sets divide_by_zero.
// If the receiver stalls, the finished result waits in the cell row until the
// output register is free, and no further request is taken meanwhile.
// Reset (rst, synchronous) empties the block: in_ready high, out_valid low.
`default_nettype none

module unsigned_divmod_64
  import udm_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      quotient,
  output logic [DATA_WIDTH-1:0]      remainder,
  output logic                       divide_by_zero
);

  ctl_t                  ctl;
  logic                  out_free;
  logic                  sel;
  logic                  dz;
  logic [DATA_WIDTH-1:0] q_vec;
  logic [DATA_WIDTH-1:0] r_vec;
  logic [DATA_WIDTH-1:0] d_vec;
  logic [DATA_WIDTH-1:0] q_shift;
  logic [DATA_WIDTH-1:0] r_shift;
  logic [DATA_WIDTH:0]   brw;

  assign out_free = !out_valid || out_ready;

  udm_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Neighbour links: the remainder takes the next dividend bit at its bottom,
  // and the quotient takes the new quotient bit at its bottom.
  assign r_shift = {r_vec[DATA_WIDTH-2:0], q_vec[DATA_WIDTH-1]};
  assign q_shift = {q_vec[DATA_WIDTH-2:0], sel};
  assign brw[0]  = 1'b0;

  // The subtraction is kept when the bit shifted out of the remainder is set
  // or when the row produced no borrow.
  assign sel = r_vec[DATA_WIDTH-1] | ~brw[DATA_WIDTH];

  // Row of bit cells.
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    udm_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .q_init     (dividend[i]),
      .d_init     (divisor[i]),
      .q_in       (q_shift[i]),
      .r_in       (r_shift[i]),
      .sel        (sel),
      .borrow_in  (brw[i]),
      .q          (q_vec[i]),
      .r          (r_vec[i]),
      .borrow_out (brw[i+1]),
      .d          (d_vec[i])
    );
  end

  // Divide-by-zero flag of the request in flight.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dz <= (divisor == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      quotient       <= dz ? '0 : q_vec;
      remainder      <= dz ? '0 : r_vec;
      divide_by_zero <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> out_free) else $error("result overwrote a pending one");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> out_valid) else $error("result not presented");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (quotient == '0 && remainder == '0))
    else $error("non-zero result on divide by zero");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (ctl.finish && !dz) |-> (r_vec < d_vec)) else $error("remainder not reduced");
`endif

endmodule

`default_nettype wire

@@ tb/unsigned_divmod_64_tb.sv @@
`timescale 1ns / 1ps

module unsigned_divmod_64_tb
  import udm_pkg::*;
();

  localparam int W = DATA_WIDTH_DEFAULT;
  localparam int LATENCY = W + 2;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REQUESTS_PER_PHASE = 380;
  localparam int REPORT_LIMIT = 10;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } divmod_t;

  // Keeps the quotients and remainders still owed by the divider, oldest first.
  class divmod_scoreboard;
    divmod_t owed[$];
    int      failures;

    function new();
      failures = 0;
    endfunction

    // Truncating unsigned division; a zero divisor raises the flag and zeroes both results.
    function divmod_t divide(word_t num, word_t den);
      divmod_t res;
      if (den == '0) begin
        res.quotient       = '0;
        res.remainder      = '0;
        res.divide_by_zero = 1'b1;
      end else begin
        res.quotient       = num / den;
        res.remainder      = num % den;
        res.divide_by_zero = 1'b0;
      end
      return res;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void note_request(word_t num, word_t den);
      owed.push_back(divide(num, den));
    endfunction

    function void check_result(word_t q, word_t r, logic z);
      divmod_t want;
      if (owed.size() == 0) begin
        flag($sformatf("result with none owed: q=%h r=%h dbz=%b", q, r, z));
        return;
      end
      want = owed.pop_front();
      if (q !== want.quotient) begin
        flag($sformatf("quotient: expected %h, got %h", want.quotient, q));
      end
      if (r !== want.remainder) begin
        flag($sformatf("remainder: expected %h, got %h", want.remainder, r));
      end
      if (z !== want.divide_by_zero) begin
        flag($sformatf("divide_by_zero: expected %b, got %b", want.divide_by_zero, z));
      end
    endfunction

    function void close();
      if (owed.size() != 0) begin
        flag($sformatf("%0d results never arrived", owed.size()));
      end
    endfunction
  endclass

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  word_t dividend;
  word_t divisor;
  logic  out_valid;
  logic  out_ready;
  word_t quotient;
  word_t remainder;
  logic  divide_by_zero;

  divmod_scoreboard board;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off_start = 1'b0;

  unsigned_divmod_64 #(
    .DATA_WIDTH(W)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .dividend       (dividend),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off counted here when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result taken at a rising edge is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(quotient, remainder, divide_by_zero);
    end
  end

  // Offers one request, with random idle cycles first; returns just after a falling edge.
  task automatic send_division(input word_t num, input word_t den);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    dividend <= num;
    divisor  <= den;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(num, den);
    @(negedge clk);
  endtask

  function automatic word_t random_word();
    return {$urandom, $urandom};
  endfunction

  // Random request, full-range in part, otherwise in one of the shapes that matter to a divider.
  task automatic send_random_division();
    word_t num;
    word_t den;
    int    shape;
    num   = random_word();
    den   = random_word();
    shape = $urandom_range(9);
    case (shape)
      3: begin
        den = den >> $urandom_range(W - 1);
      end
      4: begin
        den = word_t'(1) << $urandom_range(W - 1);
      end
      5: begin
        num = den;
      end
      6: begin
        den = den >> $urandom_range(W / 2);
        num = (den == '0) ? '0 : num % den;
      end
      7: begin
        den[W-1] = 1'b1;
        if ($urandom_range(1)) num[W-1] = 1'b1;
      end
      8: begin
        if ($urandom_range(2) == 0) den = '0;
        else den = word_t'($urandom_range(255, 1));
      end
      9: begin
        num = num >> $urandom_range(W - 1);
        den = den >> $urandom_range(W - 1);
      end
      default: begin
      end
    endcase
    send_division(num, den);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    board    = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    dividend = '0;
    divisor  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests: extremes, division by zero, equal and small operands, top-bit divisors.
    send_idle_pct = 8;
    recv_idle_pct = 50;
    send_division('0, '0);
    send_division('1, '0);
    send_division(64'h0123_4567_89ab_cdef, '0);
    send_division('0, 64'd1);
    send_division('1, 64'd1);
    send_division('1, '1);
    send_division('0, '1);
    send_division(64'd1, '1);
    send_division('1 - 64'd1, '1);
    send_division('1, 64'h8000_0000_0000_0000);
    send_division(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_division(64'hffff_ffff_ffff_fffe, 64'h8000_0000_0000_0001);
    send_division(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
    send_division(64'h1234_5678_9abc_def0, 64'h0000_0000_0000_1000);
    send_division(64'hfedc_ba98_7654_3210, 64'h0000_0001_0000_0000);
    send_division(64'h0000_0000_dead_beef, 64'h0000_0000_dead_beef);
    send_division(64'd5, 64'd3);
    send_division(64'd3, 64'd5);
    send_division('1, 64'd2);
    send_division('1, 64'd3);
    send_division(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain();

    // Random phases: sender lightly idle, then receiver lightly idle, then no random idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 8 : 0;
      for (int i = 0; i < REQUESTS_PER_PHASE; i++) begin
        // The long hold-off fills the divider while requests keep coming.
        if (phase == 2 && i == 50) hold_off_start = 1'b1;
        send_random_division();
      end
      drain();
    end

    repeat (LATENCY) @(negedge clk);
    board.close();
    if (board.failures == 0) begin
      $display("unsigned_divmod_64_tb: clean");
    end else begin
      $display("unsigned_divmod_64_tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("unsigned_divmod_64_tb: errors");
    $finish;
  end

endmodule
